// ----- sv/frpc_pkg.sv -----
// ----------------------------------------------------------------------------
// frpc_pkg
// Types and constants shared by the framed packet receiver (CRC-8) modules.
// ----------------------------------------------------------------------------
package frpc_pkg;

    localparam logic [7:0] START_TOKEN = 8'hAB;
    localparam logic [7:0] CRC_SEED    = 8'h8F;
    localparam logic [7:0] CRC_POLY    = 8'h8C;
    localparam logic [7:0] LSB_MASK    = 8'h01;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CHECK = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic       crc_ok;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] declared_length;
        logic [7:0] received_count;
    } status_t;

endpackage

// ----- sv/frpc_crc8.sv -----
// ----------------------------------------------------------------------------
// frpc_crc8
// One-byte update of the reflected CRC-8 (polynomial 0x8C, LSB first).
// ----------------------------------------------------------------------------
module frpc_crc8
    import frpc_pkg::*;
(
    input  logic [7:0] crc_in,
    input  logic [7:0] data_in,
    output logic [7:0] crc_out
);

    always_comb begin
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = data_in;
        for (int k = 0; k < 8; k++) begin
            if (((c ^ d) & LSB_MASK) != 8'h00) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        crc_out = c;
    end

endmodule

// ----- sv/frpc_deframer.sv -----
// ----------------------------------------------------------------------------
// frpc_deframer
// Frame state machine: token hunt, length, payload and check byte phases.
// Updates its state once per processed transaction.
// ----------------------------------------------------------------------------
module frpc_deframer
    import frpc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_valid,
    input  item_t   item,
    output logic    res_valid,
    output result_t res,
    output status_t status
);

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] crc_acc;
    logic [7:0] crc_upd;
    logic [7:0] count_inc;

    assign crc_acc   = (phase_reg == PH_LEN) ? CRC_SEED : crc_reg;
    assign count_inc = count_reg + 8'd1;

    frpc_crc8 u_crc (
        .crc_in  (crc_acc),
        .data_in (item.rx_byte),
        .crc_out (crc_upd)
    );

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (item.opcode == OP_IDLE) begin
            phase_next = PH_HUNT;
        end else begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (item.rx_byte == START_TOKEN) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    crc_next   = crc_upd;
                    len_next   = item.rx_byte;
                    count_next = 8'd0;
                    phase_next = (item.rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
                end
                PH_DATA: begin
                    crc_next         = crc_upd;
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = item.rx_byte;
                    res.byte_index   = count_reg;
                    count_next       = count_inc;
                    if (count_inc == len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_FRAME_END;
                    res.frame_length = len_reg;
                    res.crc_ok       = (item.rx_byte == crc_reg);
                    phase_next       = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            crc_reg   <= 8'd0;
        end else if (item_valid) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    assign status.phase           = phase_reg;
    assign status.declared_length = len_reg;
    assign status.received_count  = count_reg;

endmodule

// ----- sv/framed_packet_receiver_crc8_top.sv -----
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc8_top
// Deframes length-prefixed packets with a CRC-8 check from a UART byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per received event. s_tuser is the opcode
//   (0 = byte, 1 = line idle), s_tdata carries the received byte.
//   m_ channel: one transaction per payload byte (m_tuser = 0) with its index,
//   and one per check byte (m_tuser = 1) with the declared length and the
//   crc_ok flag. Token, length byte, dropped bytes and idle events give none.
//   Path: an input transaction is held in the input register, then its
//   result in the result register, which drives m_tvalid.
//   Throughput: one transaction per cycle unless a result is stalled; the
//   CRC-8 update and state machine between the registers are combinational.
//   Stall: while m_tready is low and a result is held, an input that makes
//   a result waits in the input register; s_tready drops once it is full.
//   Reset: aresetn low (synchronous) empties both registers and returns the
//   receiver to token hunting with length, count and CRC cleared.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc8_top
    import frpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                   // [23:16] frame_length, [24] crc_ok
    output logic        m_tuser    // [0] kind
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    advance;
    logic    res_valid;
    result_t res;
    status_t status;

    frpc_deframer u_deframer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item       (in_item_reg),
        .res_valid  (res_valid),
        .res        (res),
        .status     (status)
    );

    // an item without a result may move on even while the output is stalled
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !res_valid);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.opcode  <= s_tuser;
            in_item_reg.rx_byte <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if ((!out_valid_reg || m_tready) && advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {7'd0, out_res_reg.crc_ok, out_res_reg.frame_length,
                       out_res_reg.byte_index, out_res_reg.payload_byte};

`ifndef SYNTHESIS
    a_end_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_FRAME_END) |-> (m_tdata[15:0] == 16'd0))
        else $error("frame-end result carries payload fields");

    a_payload_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PAYLOAD) |-> (m_tdata[24:16] == 9'd0))
        else $error("payload result carries frame-end fields");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    a_idle_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.opcode == OP_IDLE) |=> (status.phase == PH_HUNT))
        else $error("line idle did not return to hunting");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.phase == PH_DATA) |-> (status.received_count < status.declared_length))
        else $error("payload count ran past declared length");
`endif

endmodule
